// ----- src/bayer_bilinear_demosaic_top_macros.svh -----
// Assertion macros shared by the demosaic RTL files.
`ifndef BAYER_BILINEAR_DEMOSAIC_TOP_MACROS_SVH
`define BAYER_BILINEAR_DEMOSAIC_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BBD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BBD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bbd_pkg.sv -----
// Shared types and constants of the Bayer bilinear demosaic block.
package bbd_pkg;

    localparam int FW_BITS   = 13;
    localparam int FH_BITS   = 16;
    localparam int PAT_BITS  = 2;
    localparam int ROW_BITS  = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAYER_PATTERN = 2'd2;

    localparam logic [PAT_BITS-1:0] PAT_GRBG = 2'd0;
    localparam logic [PAT_BITS-1:0] PAT_BGGR = 2'd1;
    localparam logic [PAT_BITS-1:0] PAT_RGGB = 2'd2;
    localparam logic [PAT_BITS-1:0] PAT_GBRG = 2'd3;

    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;
    localparam int MIN_FRAME_SIZE     = 3;

    typedef struct packed {
        logic emit;
        logic podd;
        logic qodd;
        logic line_end;
        logic frame_end;
    } bbd_ctrl_t;

endpackage

// ----- src/bbd_if.sv -----
// Handshake interfaces for the pixel input, color output and configuration channels.
interface bbd_pix_if #(parameter int PIXEL_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] raw_pixel;
    logic                  frame_start;

    modport source (output valid, output raw_pixel, output frame_start, input ready);
    modport sink (input valid, input raw_pixel, input frame_start, output ready);
endinterface

interface bbd_rgb_if #(parameter int PIXEL_BITS = 16);
    logic                    valid;
    logic                    ready;
    logic [PIXEL_BITS+1:0]   red_x4;
    logic [PIXEL_BITS+1:0]   green_x4;
    logic [PIXEL_BITS+1:0]   blue_x4;
    logic                    line_end;
    logic                    frame_end;

    modport source (output valid, output red_x4, output green_x4, output blue_x4,
                    output line_end, output frame_end, input ready);
    modport sink (input valid, input red_x4, input green_x4, input blue_x4,
                  input line_end, input frame_end, output ready);
endinterface

interface bbd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [bbd_pkg::CFG_IDX_BITS-1:0]     index;
    logic [bbd_pkg::CFG_DATA_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/bayer_bilinear_demosaic_top.sv -----
// Top level of the streaming bilinear Bayer demosaic with configuration registers.
// The block takes one raw pixel per clock in raster order and returns red, green and blue,
// each scaled by four, for every interior pixel; border pixels give no result. The
// transfer edge captures the pixel and the registered line memory read into the first
// stage, and the edge on which that stage advances loads the window update and the
// color sums into the output register, which presents the result. Pixels are taken
// every clock while the consumer takes each result in the cycle it is presented; while
// a result waits in the output register and the pixel behind it also gives a result,
// the input stalls until the consumer takes the waiting one. After reset the two line
// memories are cleared one entry per clock; no pixel is accepted during that sweep,
// while configuration writes are taken at any time. Configuration registers should be
// written only while the pipeline is empty.
module bayer_bilinear_demosaic_top #(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int PIXEL_BITS      = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    bbd_pix_if.sink   pix,
    bbd_rgb_if.source rgb,
    bbd_cfg_if.sink   cfg
);
    `include "bayer_bilinear_demosaic_top_macros.svh"

    localparam int COL_BITS = $clog2(MAX_LINE_PIXELS);
    localparam int CNT_BITS = $clog2(MAX_LINE_PIXELS + 1);
    localparam int WB = (CNT_BITS > bbd_pkg::FW_BITS) ? CNT_BITS : bbd_pkg::FW_BITS;
    localparam int RB = bbd_pkg::ROW_BITS;
    localparam int OW = PIXEL_BITS + 2;
    localparam int W_RESET = (bbd_pkg::FRAME_WIDTH_RESET > MAX_LINE_PIXELS)
                           ? MAX_LINE_PIXELS : bbd_pkg::FRAME_WIDTH_RESET;
    localparam logic [COL_BITS-1:0] W_LAST_RESET = COL_BITS'(W_RESET - 1);
    localparam logic [RB-1:0] H_LAST_RESET = RB'(bbd_pkg::FRAME_HEIGHT_RESET - 1);
    localparam logic [WB-1:0] W_MIN = WB'(bbd_pkg::MIN_FRAME_SIZE);
    localparam logic [WB-1:0] W_MAX = WB'(MAX_LINE_PIXELS);
    localparam logic [RB-1:0] H_MIN = RB'(bbd_pkg::MIN_FRAME_SIZE);
    localparam logic [COL_BITS-1:0] COL_TWO = COL_BITS'(2);
    localparam logic [RB-1:0] ROW_TWO = RB'(2);

    // Configuration, stored as last column and last row in use.
    logic [COL_BITS-1:0]           w_last_reg;
    logic [RB-1:0]                 h_last_reg;
    logic [bbd_pkg::PAT_BITS-1:0]  pattern_reg;
    logic [WB-1:0]                 fw_ext;
    logic [WB-1:0]                 fw_used;
    logic [RB-1:0]                 fh_used;
    logic                          cfg_xfer;

    // Position counters and front-end decode.
    logic [COL_BITS-1:0] col_reg;
    logic [COL_BITS-1:0] col_next;
    logic [RB-1:0]       row_reg;
    logic [RB-1:0]       row_next;
    logic [COL_BITS-1:0] col_start;
    logic [RB-1:0]       row_cur;
    logic [COL_BITS-1:0] col_cur;
    logic                ox;
    logic                oy;
    bbd_pkg::bbd_ctrl_t  ctrl_s0;

    // Pipeline control.
    logic                  in_xfer;
    logic                  store_busy;
    logic                  s1_vld_reg;
    logic                  s1_vld_next;
    bbd_pkg::bbd_ctrl_t    s1_ctrl_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  adv1;
    logic [PIXEL_BITS-1:0] up_q;
    logic [PIXEL_BITS-1:0] mid_q;

    // Output register.
    logic [OW-1:0] red_w;
    logic [OW-1:0] green_w;
    logic [OW-1:0] blue_w;
    logic          out_vld_reg;
    logic          out_vld_next;
    logic [OW-1:0] red_reg;
    logic [OW-1:0] green_reg;
    logic [OW-1:0] blue_reg;
    logic          line_end_reg;
    logic          frame_end_reg;

    assign cfg.ready = 1'b1;
    assign cfg_xfer  = cfg.valid & cfg.ready;

    always_comb
    begin
        fw_ext = WB'(cfg.data[bbd_pkg::FW_BITS-1:0]);
        if (fw_ext < W_MIN)
        begin
            fw_used = W_MIN;
        end
        else if (fw_ext > W_MAX)
        begin
            fw_used = W_MAX;
        end
        else
        begin
            fw_used = fw_ext;
        end
        if (cfg.data[bbd_pkg::FH_BITS-1:0] < H_MIN)
        begin
            fh_used = H_MIN;
        end
        else
        begin
            fh_used = cfg.data[bbd_pkg::FH_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg  <= W_LAST_RESET;
            h_last_reg  <= H_LAST_RESET;
            pattern_reg <= bbd_pkg::PAT_RGGB;
        end
        else if (cfg_xfer)
        begin
            unique case (cfg.index)
                bbd_pkg::CFG_FRAME_WIDTH:
                begin
                    w_last_reg <= COL_BITS'(fw_used - 1'b1);
                end
                bbd_pkg::CFG_FRAME_HEIGHT:
                begin
                    h_last_reg <= fh_used - 1'b1;
                end
                bbd_pkg::CFG_BAYER_PATTERN:
                begin
                    pattern_reg <= cfg.data[bbd_pkg::PAT_BITS-1:0];
                end
                default:
                begin
                    pattern_reg <= pattern_reg;
                end
            endcase
        end
    end

    assign pix.ready = !store_busy && (!s1_vld_reg || adv1);
    assign in_xfer   = pix.valid & pix.ready;

    always_comb
    begin
        col_start = pix.frame_start ? '0 : col_reg;
        row_cur   = pix.frame_start ? '0 : row_reg;
        col_cur   = (col_start > w_last_reg) ? '0 : col_start;

        if (col_cur == w_last_reg)
        begin
            col_next = '0;
            row_next = (row_cur >= h_last_reg) ? '0 : row_cur + 1'b1;
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end

        ox = (pattern_reg == bbd_pkg::PAT_RGGB) || (pattern_reg == bbd_pkg::PAT_GBRG);
        oy = (pattern_reg == bbd_pkg::PAT_BGGR) || (pattern_reg == bbd_pkg::PAT_GBRG);

        ctrl_s0.emit      = (col_cur >= COL_TWO) && (row_cur >= ROW_TWO)
                          && (row_cur <= h_last_reg);
        ctrl_s0.podd      = ~(col_cur[0] ^ ox);
        ctrl_s0.qodd      = ~(row_cur[0] ^ oy);
        ctrl_s0.line_end  = (col_cur == w_last_reg);
        ctrl_s0.frame_end = (col_cur == w_last_reg) && (row_cur == h_last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    bbd_line_store #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .PIXEL_BITS      (PIXEL_BITS)
    ) u_line_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (in_xfer),
        .addr  (col_cur),
        .pix   (pix.raw_pixel),
        .wb_en (adv1),
        .up_q  (up_q),
        .mid_q (mid_q),
        .busy  (store_busy)
    );

    assign adv1 = s1_vld_reg && (!s1_ctrl_reg.emit || !out_vld_reg || rgb.ready);

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (in_xfer)
        begin
            s1_vld_next = 1'b1;
        end
        else if (adv1)
        begin
            s1_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_ctrl_reg <= ctrl_s0;
            s1_pix_reg  <= pix.raw_pixel;
        end
    end

    bbd_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .clk      (clk),
        .load     (adv1),
        .up       (up_q),
        .mid      (mid_q),
        .pix      (s1_pix_reg),
        .ctrl     (s1_ctrl_reg),
        .red_x4   (red_w),
        .green_x4 (green_w),
        .blue_x4  (blue_w)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (adv1 && s1_ctrl_reg.emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (rgb.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s1_ctrl_reg.emit)
        begin
            red_reg       <= red_w;
            green_reg     <= green_w;
            blue_reg      <= blue_w;
            line_end_reg  <= s1_ctrl_reg.line_end;
            frame_end_reg <= s1_ctrl_reg.frame_end;
        end
    end

    assign rgb.valid     = out_vld_reg;
    assign rgb.red_x4    = red_reg;
    assign rgb.green_x4  = green_reg;
    assign rgb.blue_x4   = blue_reg;
    assign rgb.line_end  = line_end_reg;
    assign rgb.frame_end = frame_end_reg;

    `BBD_ASSERT_IMP(a_frame_end_on_line_end, clk, rst_n, out_vld_reg && frame_end_reg,
        line_end_reg, "frame end without line end")
    `BBD_ASSERT_IMP(a_stall_only_on_full_out, clk, rst_n, s1_vld_reg && !adv1,
        out_vld_reg && !rgb.ready && s1_ctrl_reg.emit, "pipeline stalled without cause")
    `BBD_ASSERT_NXT(a_emit_loads_output, clk, rst_n, adv1 && s1_ctrl_reg.emit,
        out_vld_reg, "result lost on its way to the output register")

endmodule

// ----- src/bbd_line_store.sv -----
// Two line memories with a clearing sweep after reset and upper-line write-back.
module bbd_line_store #(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int PIXEL_BITS      = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               rd_en,
    input  logic [$clog2(MAX_LINE_PIXELS)-1:0] addr,
    input  logic [PIXEL_BITS-1:0]              pix,
    input  logic                               wb_en,
    output logic [PIXEL_BITS-1:0]              up_q,
    output logic [PIXEL_BITS-1:0]              mid_q,
    output logic                               busy
);
    `include "bayer_bilinear_demosaic_top_macros.svh"

    localparam int COL_BITS = $clog2(MAX_LINE_PIXELS);
    localparam logic [COL_BITS-1:0] LAST_ADDR = COL_BITS'(MAX_LINE_PIXELS - 1);

    logic [PIXEL_BITS-1:0] upper_mem [MAX_LINE_PIXELS];
    logic [PIXEL_BITS-1:0] middle_mem [MAX_LINE_PIXELS];

    logic                  busy_reg;
    logic                  busy_next;
    logic [COL_BITS-1:0]   clr_addr_reg;
    logic [COL_BITS-1:0]   clr_addr_next;
    logic [COL_BITS-1:0]   wb_addr_reg;
    logic [PIXEL_BITS-1:0] up_q_reg;
    logic [PIXEL_BITS-1:0] mid_q_reg;

    logic                  up_we;
    logic [COL_BITS-1:0]   up_waddr;
    logic [PIXEL_BITS-1:0] up_wdata;
    logic                  mid_we;
    logic [COL_BITS-1:0]   mid_waddr;
    logic [PIXEL_BITS-1:0] mid_wdata;

    always_comb
    begin
        busy_next     = busy_reg;
        clr_addr_next = clr_addr_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        up_we     = busy_reg | wb_en;
        up_waddr  = busy_reg ? clr_addr_reg : wb_addr_reg;
        up_wdata  = busy_reg ? '0 : mid_q_reg;
        mid_we    = busy_reg | rd_en;
        mid_waddr = busy_reg ? clr_addr_reg : addr;
        mid_wdata = busy_reg ? '0 : pix;
    end

    always_ff @(posedge clk)
    begin
        if (up_we)
        begin
            upper_mem[up_waddr] <= up_wdata;
        end
        if (rd_en)
        begin
            if (wb_en && (wb_addr_reg == addr))
            begin
                up_q_reg <= mid_q_reg;
            end
            else
            begin
                up_q_reg <= upper_mem[addr];
            end
            wb_addr_reg <= addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_we)
        begin
            middle_mem[mid_waddr] <= mid_wdata;
        end
        if (rd_en)
        begin
            mid_q_reg <= middle_mem[addr];
        end
    end

    assign up_q  = up_q_reg;
    assign mid_q = mid_q_reg;
    assign busy  = busy_reg;

    `BBD_ASSERT_IMP(a_no_read_in_clear, clk, rst_n, rd_en, !busy_reg, "read during clear")
    `BBD_ASSERT_IMP(a_no_wb_in_clear, clk, rst_n, wb_en, !busy_reg, "write-back during clear")
    `BBD_ASSERT_IMP(a_clear_complete, clk, rst_n, $fell(busy_reg),
        $past(clr_addr_reg) == LAST_ADDR, "clear sweep ended early")

endmodule

// ----- src/bbd_window.sv -----
// 3x3 window registers and the bilinear color selection for the window center.
module bbd_window #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic [PIXEL_BITS-1:0] up,
    input  logic [PIXEL_BITS-1:0] mid,
    input  logic [PIXEL_BITS-1:0] pix,
    input  bbd_pkg::bbd_ctrl_t    ctrl,
    output logic [PIXEL_BITS+1:0] red_x4,
    output logic [PIXEL_BITS+1:0] green_x4,
    output logic [PIXEL_BITS+1:0] blue_x4
);
    localparam int OW = PIXEL_BITS + 2;

    logic [PIXEL_BITS-1:0] win_reg  [3][3];
    logic [PIXEL_BITS-1:0] win_next [3][3];

    logic [OW-1:0] centre;
    logic [OW-1:0] horiz;
    logic [OW-1:0] vert;
    logic [OW-1:0] cross_sum;
    logic [OW-1:0] diag;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = up;
        win_next[1][2] = mid;
        win_next[2][2] = pix;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        centre    = {win_next[1][1], 2'b00};
        horiz     = {(OW-1)'(win_next[1][0]) + (OW-1)'(win_next[1][2]), 1'b0};
        vert      = {(OW-1)'(win_next[0][1]) + (OW-1)'(win_next[2][1]), 1'b0};
        cross_sum = OW'(win_next[1][0]) + OW'(win_next[1][2])
                  + OW'(win_next[0][1]) + OW'(win_next[2][1]);
        diag      = OW'(win_next[0][0]) + OW'(win_next[0][2])
                  + OW'(win_next[2][0]) + OW'(win_next[2][2]);
    end

    always_comb
    begin
        if (ctrl.podd && ctrl.qodd)
        begin
            red_x4   = vert;
            green_x4 = centre;
            blue_x4  = horiz;
        end
        else if (!ctrl.podd && !ctrl.qodd)
        begin
            red_x4   = horiz;
            green_x4 = centre;
            blue_x4  = vert;
        end
        else if (ctrl.podd)
        begin
            red_x4   = centre;
            green_x4 = cross_sum;
            blue_x4  = diag;
        end
        else
        begin
            red_x4   = diag;
            green_x4 = cross_sum;
            blue_x4  = centre;
        end
    end

endmodule

// ----- tb/tb_bayer_bilinear_demosaic_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench that streams Bayer frames through the demosaic block.
module tb_bayer_bilinear_demosaic_top;

    localparam int LINE_PIXELS  = 4096;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1350;
    localparam logic [bbd_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_start;
    } raw_t;

    typedef struct packed {
        logic [17:0] red;
        logic [17:0] green;
        logic [17:0] blue;
        logic        line_end;
        logic        frame_end;
    } rgb_t;

    logic clk;
    logic rst_n;

    bbd_pix_if #(.PIXEL_BITS(16)) pix_ch ();
    bbd_rgb_if #(.PIXEL_BITS(16)) rgb_ch ();
    bbd_cfg_if cfg_ch ();

    bayer_bilinear_demosaic_top #(
        .MAX_LINE_PIXELS(LINE_PIXELS),
        .PIXEL_BITS(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .pix(pix_ch),
        .rgb(rgb_ch),
        .cfg(cfg_ch)
    );

    raw_t        raw_backlog[$];
    rgb_t        expected_rgb[$];
    logic [15:0] upper_line[LINE_PIXELS];
    logic [15:0] middle_line[LINE_PIXELS];
    logic [15:0] win[3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [12:0] cur_width;
    logic [15:0] cur_height;
    logic [1:0]  cur_pattern;

    bit          pix_took;
    bit          calm;
    bit          want_hold;
    bit          hold_done;
    int          hold_left;
    int unsigned pixels_queued;
    int unsigned pixels_taken;
    int unsigned results_seen;
    int unsigned cfg_writes;
    int unsigned mismatches;
    int unsigned stall_cycles;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic advance_mosaic(input logic [15:0] pixel, input logic fs);
        int unsigned w, h, c, r, x, y, cen, hor, ver, crs, dia;
        logic [15:0] up, mid;
        bit ox, oy, podd, qodd;
        rgb_t res;
        w = 32'(cur_width);
        if (w < bbd_pkg::MIN_FRAME_SIZE) w = bbd_pkg::MIN_FRAME_SIZE;
        if (w > LINE_PIXELS) w = LINE_PIXELS;
        h = 32'(cur_height);
        if (h < bbd_pkg::MIN_FRAME_SIZE) h = bbd_pkg::MIN_FRAME_SIZE;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c = col_pos;
        r = row_pos;
        if (c >= w) c = 0;
        up = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = pixel;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pixel;
        if (c >= 2 && r >= 2 && r < h)
        begin
            x = c - 1;
            y = r - 1;
            ox = (cur_pattern == bbd_pkg::PAT_RGGB) || (cur_pattern == bbd_pkg::PAT_GBRG);
            oy = (cur_pattern == bbd_pkg::PAT_BGGR) || (cur_pattern == bbd_pkg::PAT_GBRG);
            podd = x[0] ^ ox;
            qodd = y[0] ^ oy;
            cen = 4 * win[1][1];
            hor = 2 * (win[1][0] + win[1][2]);
            ver = 2 * (win[0][1] + win[2][1]);
            crs = win[1][0] + win[1][2] + win[0][1] + win[2][1];
            dia = win[0][0] + win[0][2] + win[2][0] + win[2][2];
            if (podd && qodd)
            begin
                res.red = 18'(ver); res.green = 18'(cen); res.blue = 18'(hor);
            end
            else if (!podd && !qodd)
            begin
                res.red = 18'(hor); res.green = 18'(cen); res.blue = 18'(ver);
            end
            else if (podd)
            begin
                res.red = 18'(cen); res.green = 18'(crs); res.blue = 18'(dia);
            end
            else
            begin
                res.red = 18'(dia); res.green = 18'(crs); res.blue = 18'(cen);
            end
            res.line_end = (c == w - 1);
            res.frame_end = (c == w - 1) && (r == h - 1);
            expected_rgb.push_back(res);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c & 32'hFFF;
        row_pos = r & 32'hFFFF;
    endtask

    always @(posedge clk)
    begin
        pix_took = 1'b0;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            advance_mosaic(pix_ch.raw_pixel, pix_ch.frame_start);
            pixels_taken++;
            pix_took = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        raw_t next_raw;
        if (rst_n && (!pix_ch.valid || pix_took))
        begin
            if (raw_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 6))
            begin
                next_raw = raw_backlog.pop_front();
                pix_ch.valid <= 1'b1;
                pix_ch.raw_pixel <= next_raw.pixel;
                pix_ch.frame_start <= next_raw.frame_start;
            end
            else
                pix_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (want_hold && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rgb_ch.ready <= 1'b0;
        end
        else
            rgb_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge clk)
    begin
        rgb_t got, want;
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
        begin
            got = {rgb_ch.red_x4, rgb_ch.green_x4, rgb_ch.blue_x4,
                   rgb_ch.line_end, rgb_ch.frame_end};
            results_seen++;
            if (expected_rgb.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result r=%0d g=%0d b=%0d le=%0b fe=%0b",
                             got.red, got.green, got.blue, got.line_end, got.frame_end);
            end
            else
            begin
                want = expected_rgb.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.line_end !== want.line_end ||
                    got.frame_end !== want.frame_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Result %0d: expected r=%0d g=%0d b=%0d le=%0b fe=%0b,",
                                  " got r=%0d g=%0d b=%0d le=%0b fe=%0b"},
                                 results_seen, want.red, want.green, want.blue,
                                 want.line_end, want.frame_end, got.red, got.green,
                                 got.blue, got.line_end, got.frame_end);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (rgb_ch.valid && rgb_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [bbd_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            bbd_pkg::CFG_FRAME_WIDTH:   cur_width = value[12:0];
            bbd_pkg::CFG_FRAME_HEIGHT:  cur_height = value;
            bbd_pkg::CFG_BAYER_PATTERN: cur_pattern = value[1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixels_taken != pixels_queued || expected_rgb.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input logic [1:0] pat);
        wait_idle();
        write_reg(bbd_pkg::CFG_FRAME_WIDTH, {3'($urandom), 13'(w)});
        write_reg(bbd_pkg::CFG_FRAME_HEIGHT, 16'(h));
        write_reg(bbd_pkg::CFG_BAYER_PATTERN, {14'($urandom), pat});
    endtask

    task automatic queue_pixel(input logic [15:0] value, input logic fs);
        raw_backlog.push_back('{pixel: value, frame_start: fs});
        pixels_queued++;
    endtask

    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 19))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_frames(input int unsigned w, input int unsigned h,
                                input int unsigned frames, input bit lead_start,
                                input bit noisy);
        int unsigned total;
        bit fs;
        total = frames * w * h;
        if (noisy && $urandom_range(0, 1)) total = $urandom_range(1, total);
        for (int unsigned k = 0; k < total; k++)
        begin
            fs = (k == 0) && lead_start;
            if (k != 0 && k % (w * h) == 0 && $urandom_range(0, 1)) fs = 1'b1;
            if (noisy && $urandom_range(0, 99) < 3) fs = 1'b1;
            queue_pixel(pick_pixel(), fs);
        end
    endtask

    initial
    begin : stimulus
        int unsigned random_items, queued_prior, wdata, hdata, wuse, huse, frames, phase;
        bit lead_start, noisy;
        rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.raw_pixel = '0;
        pix_ch.frame_start = 1'b0;
        rgb_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        for (int i = 0; i < LINE_PIXELS; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                win[i][j] = '0;
        col_pos = 0;
        row_pos = 0;
        cur_width = 13'(bbd_pkg::FRAME_WIDTH_RESET);
        cur_height = 16'(bbd_pkg::FRAME_HEIGHT_RESET);
        cur_pattern = bbd_pkg::PAT_RGGB;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full-scale 4x4 frame reaches every site class at maximum sums.
        set_geometry(4, 4, bbd_pkg::PAT_GRBG);
        for (int k = 0; k < 16; k++)
            queue_pixel(16'hFFFF, k == 0);
        // Undersized registers saturate to 3x3; the frame follows without a start mark.
        set_geometry(2, 0, bbd_pkg::PAT_GBRG);
        for (int k = 0; k < 9; k++)
            queue_pixel(k[0] ? 16'hFFFF : 16'h0000, 1'b0);
        wait_idle();
        write_reg(CFG_UNUSED, 16'($urandom));

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            phase++;
            calm = (random_items >= 600 && random_items < 900);
            wdata = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            hdata = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            wuse = (wdata < 3) ? 3 : wdata;
            huse = (hdata < 3) ? 3 : hdata;
            set_geometry(wdata, hdata, 2'($urandom_range(0, 3)));
            frames = $urandom_range(1, 3);
            lead_start = ($urandom_range(0, 4) != 0);
            noisy = ($urandom_range(0, 3) == 0);
            if (phase == 3)
            begin
                want_hold = 1'b1;
                frames = 4;
                noisy = 1'b0;
            end
            queued_prior = pixels_queued;
            queue_frames(wuse, huse, frames, lead_start, noisy);
            random_items += pixels_queued - queued_prior;
        end
        calm = 1'b0;

        wait_idle();
        write_reg(bbd_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
        write_reg(bbd_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
        write_reg(bbd_pkg::CFG_BAYER_PATTERN, 16'($urandom));
        for (int k = 0; k < 40; k++)
            queue_pixel(pick_pixel(), k == 0);
        set_geometry(3, 16'hFFFF, bbd_pkg::PAT_BGGR);
        for (int k = 0; k < 150; k++)
            queue_pixel(pick_pixel(), k == 0);

        wait_idle();
        $display("Checked %0d color results from %0d pixels across %0d register writes.",
                 results_seen, pixels_taken, cfg_writes);
        $display({"Small frames in all four layouts ran with restarts, partial frames,",
                  " out-of-range registers and a long output stall."});
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/bbd_pkg.sv
src/bbd_if.sv
src/bbd_line_store.sv
src/bbd_window.sv
src/bayer_bilinear_demosaic_top.sv
tb/tb_bayer_bilinear_demosaic_top.sv
